>>> src/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and constants of the sample ring record deframer.
// ----------------------------------------------------------------------------
package srd_pkg;

  // largest payload emitted per sample record, whatever payload_limit says
  localparam int unsigned MAX_PAYLOAD = 256;

  localparam int unsigned LIMIT_W = 9;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned POS_W   = 64;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_W   = 64;

  localparam logic [IDX_W-1:0] MAX_PAYLOAD_W = IDX_W'(MAX_PAYLOAD);

  // configuration register indexes
  localparam logic [1:0] CFG_PAYLOAD_LIMIT = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_TYPE   = 2'd1;
  localparam logic [1:0] CFG_LOST_TYPE     = 2'd2;
  localparam logic [1:0] CFG_START_POS     = 2'd3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET       = 9'd256;
  localparam logic [CODE_W-1:0]  SAMPLE_TYPE_RESET = 32'd9;
  localparam logic [CODE_W-1:0]  LOST_TYPE_RESET   = 32'd2;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // record layout
  localparam logic [IDX_W-1:0] HDR_LAST_IDX  = 16'd7;
  localparam logic [IDX_W-1:0] HDR_SIZE_IDX  = 16'd6;
  localparam logic [IDX_W-1:0] HDR_LEN       = 16'd8;
  localparam logic [IDX_W-1:0] LOST_FIRST    = 16'd16;
  localparam logic [IDX_W-1:0] LOST_LAST     = 16'd23;
  localparam logic [IDX_W-1:0] LOST_MIN_SIZE = 16'd24;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       batch_end;
  } srd_in_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [7:0]       payload_byte;
    logic             payload_last;
    logic [CNT_W-1:0] batch_samples;
    logic [POS_W-1:0] lost_total;
    logic [POS_W-1:0] consumed_position;
    logic             halted;
  } srd_result_t;

  // up to two results made by one accepted item, record result first
  typedef struct packed {
    logic        main_valid;
    srd_result_t main;
    logic        sum_valid;
    srd_result_t sum;
  } srd_push_t;

endpackage

>>> src/sample_ring_record_deframer_unit.sv
// ----------------------------------------------------------------------------
// sample_ring_record_deframer_unit
// Splits a ring byte stream into records, emits sample payload bytes,
// totals lost-event counts and reports batch summaries.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       input      in_valid / in_stall        srd_in_t (data_byte, batch_end)
//  res      output     res_valid / res_stall      srd_result_t (one result item)
//  cfg      input      cfg_we, cfg_addr, cfg_data write only, no wait
//
// one byte per cycle while in_stall is low; its results enter a four-entry
// queue at the accepting edge and leave one per cycle from the next cycle on
// while res_stall is low; a byte with a payload result and a summary gives two.
// in_stall rises while the queue holds more than two items.
// synchronous reset clears the parser state and empties the queue.
// res_stall only holds the queue head; the parser keeps working until in_stall rises.
// ----------------------------------------------------------------------------
module sample_ring_record_deframer_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  srd_pkg::srd_in_t          in_item,
  output logic                      res_valid,
  input  logic                      res_stall,
  output srd_pkg::srd_result_t      res_item,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [srd_pkg::CFG_W-1:0] cfg_data
);
  import srd_pkg::*;

  srd_push_t push;
  logic      room;
  logic      step;

  assign in_stall = !room;
  assign step     = in_valid && room;

  srd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (in_item),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .push     (push)
  );

  srd_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

>>> src/srd_parser.sv
// ----------------------------------------------------------------------------
// srd_parser
// Per-byte record parser: header capture, payload selection, lost-count
// accumulation, positions and batch sample count.
// ----------------------------------------------------------------------------
module srd_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  srd_pkg::srd_in_t         item,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_addr,
  input  logic [srd_pkg::CFG_W-1:0] cfg_data,
  output srd_pkg::srd_push_t       push
);
  import srd_pkg::*;

  logic [LIMIT_W-1:0] payload_limit;
  logic [CODE_W-1:0]  sample_code;
  logic [CODE_W-1:0]  lost_code;

  logic [CODE_W-1:0]  hdr_type;
  logic [7:0]         hdr_size_lo;
  logic [IDX_W-1:0]   rec_idx;
  logic [CODE_W-1:0]  record_type;
  logic [IDX_W-1:0]   record_size;
  logic [55:0]        lost_lo;
  logic [POS_W-1:0]   lost_sum;
  logic [POS_W-1:0]   stream_pos;
  logic [POS_W-1:0]   record_start;
  logic [CNT_W-1:0]   sample_count;
  logic               halt;

  logic               hdr_done;
  logic [IDX_W-1:0]   size_now;
  logic [CODE_W-1:0]  type_now;
  logic               bad_size;
  logic               halt_next;
  logic               is_sample;
  logic               is_lost;
  logic [IDX_W-1:0]   lim_eff;
  logic [IDX_W-1:0]   body;
  logic [IDX_W-1:0]   emit_len;
  logic [IDX_W-1:0]   offset;
  logic               active;
  logic               rec_end;
  logic               emit_payload;
  logic               emit_empty;
  logic               lost_hit;
  logic [POS_W-1:0]   lost_sum_next;
  logic [POS_W-1:0]   record_start_next;
  logic               count_inc;
  logic [CNT_W-1:0]   count_after;
  logic               parse_on;

  always_comb begin
    hdr_done  = (rec_idx == HDR_LAST_IDX);
    size_now  = hdr_done ? {item.data_byte, hdr_size_lo} : record_size;
    type_now  = hdr_done ? hdr_type : record_type;
    bad_size  = hdr_done && (size_now < HDR_LEN);
    parse_on  = step && !halt;
    halt_next = halt || (parse_on && bad_size);
    is_sample = (type_now == sample_code);
    is_lost   = !is_sample && (type_now == lost_code);

    lim_eff  = ({7'd0, payload_limit} > MAX_PAYLOAD_W) ? MAX_PAYLOAD_W
                                                        : {7'd0, payload_limit};
    body     = (size_now >= HDR_LEN) ? size_now - HDR_LEN : '0;
    emit_len = (body < lim_eff) ? body : lim_eff;
    offset   = rec_idx - HDR_LEN;

    active  = parse_on && !bad_size && (rec_idx >= HDR_LAST_IDX);
    rec_end = (rec_idx == size_now - 16'd1);

    emit_empty   = active && is_sample && hdr_done && (emit_len == '0);
    emit_payload = active && is_sample && !hdr_done && (offset < emit_len);

    lost_hit = active && is_lost && (size_now >= LOST_MIN_SIZE) &&
               (rec_idx >= LOST_FIRST) && (rec_idx <= LOST_LAST);
    lost_sum_next = (lost_hit && rec_idx == LOST_LAST) ?
                    lost_sum + {item.data_byte, lost_lo} : lost_sum;

    record_start_next = (active && rec_end) ? stream_pos + 64'd1 : record_start;
    count_inc   = active && rec_end && is_sample && (sample_count != '1);
    count_after = sample_count + CNT_W'(count_inc);
  end

  always_comb begin
    push.main_valid             = emit_empty || emit_payload;
    push.main.result_kind       = emit_empty ? KIND_EMPTY : KIND_PAYLOAD;
    push.main.payload_byte      = emit_payload ? item.data_byte : 8'd0;
    push.main.payload_last      = emit_payload && (offset == emit_len - 16'd1);
    push.main.batch_samples     = '0;
    push.main.lost_total        = lost_sum_next;
    push.main.consumed_position = record_start_next;
    push.main.halted            = halt_next;

    push.sum_valid             = step && item.batch_end;
    push.sum.result_kind       = KIND_SUMMARY;
    push.sum.payload_byte      = 8'd0;
    push.sum.payload_last      = 1'b0;
    push.sum.batch_samples     = count_after;
    push.sum.lost_total        = lost_sum_next;
    push.sum.consumed_position = record_start_next;
    push.sum.halted            = halt_next;
  end

  // header and lost word capture, no reset needed
  always_ff @(posedge clk) begin
    if (parse_on) begin
      if (rec_idx < 16'd4) begin
        hdr_type[8*rec_idx[1:0] +: 8] <= item.data_byte;
      end
      if (rec_idx == HDR_SIZE_IDX) begin
        hdr_size_lo <= item.data_byte;
      end
      if (lost_hit && rec_idx != LOST_LAST) begin
        lost_lo[8*rec_idx[2:0] +: 8] <= item.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= LIMIT_RESET;
      sample_code   <= SAMPLE_TYPE_RESET;
      lost_code     <= LOST_TYPE_RESET;
      rec_idx       <= '0;
      record_type   <= '0;
      record_size   <= '0;
      lost_sum      <= '0;
      stream_pos    <= '0;
      record_start  <= '0;
      sample_count  <= '0;
      halt          <= 1'b0;
    end else begin
      if (step) begin
        stream_pos   <= stream_pos + 64'd1;
        lost_sum     <= lost_sum_next;
        record_start <= record_start_next;
        halt         <= halt_next;
        sample_count <= item.batch_end ? '0 : count_after;
        if (parse_on && hdr_done) begin
          record_type <= type_now;
          record_size <= size_now;
        end
        if (parse_on && !bad_size) begin
          rec_idx <= (active && rec_end) ? '0 : rec_idx + 16'd1;
        end
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_PAYLOAD_LIMIT: payload_limit <= cfg_data[LIMIT_W-1:0];
          CFG_SAMPLE_TYPE:   sample_code   <= cfg_data[CODE_W-1:0];
          CFG_LOST_TYPE:     lost_code     <= cfg_data[CODE_W-1:0];
          CFG_START_POS: begin
            stream_pos   <= cfg_data;
            record_start <= cfg_data;
            rec_idx      <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt |=> halt) else $error("halt flag cleared without reset");

  a_no_record_result_halted: assert property (@(posedge clk) disable iff (rst)
    push.main_valid |-> !push.main.halted)
    else $error("record result produced while halted");

  a_idx_in_record: assert property (@(posedge clk) disable iff (rst)
    (step && !halt && rec_idx > HDR_LAST_IDX) |-> (rec_idx < record_size))
    else $error("byte index ran past the record size");

endmodule

>>> src/srd_out_fifo.sv
// ----------------------------------------------------------------------------
// srd_out_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module srd_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  srd_pkg::srd_push_t   push,
  output logic                 room,
  output logic                 res_valid,
  input  logic                 res_stall,
  output srd_pkg::srd_result_t res_item
);
  import srd_pkg::*;

  srd_result_t        mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW-1:0] n_push;
  logic               pop;

  assign n_push    = FIFO_CW'(push.main_valid) + FIFO_CW'(push.sum_valid);
  assign res_valid = (count != '0);
  assign pop       = res_valid && !res_stall;
  assign res_item  = mem[rd_ptr];
  // room for the worst case of two results from the next item
  assign room      = (count <= FIFO_CW'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.main_valid) begin
      mem[wr_ptr] <= push.main;
      if (push.sum_valid) begin
        mem[wr_ptr + FIFO_AW'(1)] <= push.sum;
      end
    end else if (push.sum_valid) begin
      mem[wr_ptr] <= push.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[FIFO_AW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + n_push - FIFO_CW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CW'(FIFO_DEPTH)) else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (n_push != '0) |-> (count + n_push <= FIFO_CW'(FIFO_DEPTH)))
    else $error("push into a full result queue");

  a_head_stable: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res_item)))
    else $error("stalled result item changed");

endmodule
